FILE: design/pfmd_pkg.sv
// Shared types and constants for the prime-field modular divider.
package pfmd_pkg;

  // Default width of the modulus and of every operand.
  localparam int unsigned MODULUS_BITS_DEF = 11;

  // Configuration data bus width.
  localparam int unsigned CFG_DATA_BITS = 32;

  // Configuration address width; the word index sits in the top bit.
  localparam int unsigned CFG_ADDR_BITS = 3;

  // Register word indexes.
  localparam logic REG_MODULUS = 1'b0;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic found;
    logic last;
  } status_t;

endpackage

FILE: design/pfmd_regs.sv
// Configuration register file holding the field modulus.
module pfmd_regs
  import pfmd_pkg::*;
#(
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_BITS-1:0]  paddr,
  input  logic [CFG_DATA_BITS-1:0]  pwdata,
  output logic [CFG_DATA_BITS-1:0]  prdata,
  output logic                      pready,
  output logic [MODULUS_BITS-1:0]   modulus
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_BITS'(2);
    end else if (wr_en && (paddr[CFG_ADDR_BITS-1] == REG_MODULUS)) begin
      modulus <= pwdata[MODULUS_BITS-1:0];
    end
  end

  always_comb begin
    unique case (paddr[CFG_ADDR_BITS-1])
      REG_MODULUS: prdata = CFG_DATA_BITS'(modulus);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: design/pfmd_datapath.sv
// Datapath: operand registers, the descending multiple search and the result register.
module pfmd_datapath
  import pfmd_pkg::*;
#(
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic [MODULUS_BITS-1:0] modulus,
  input  logic [MODULUS_BITS-1:0] dividend,
  input  logic [MODULUS_BITS-1:0] divisor,
  output logic [MODULUS_BITS-1:0] quotient,
  output logic                    error
);

  logic [MODULUS_BITS-1:0] c_op;
  logic [MODULUS_BITS-1:0] i_op;
  logic [MODULUS_BITS-1:0] p_op;
  logic [MODULUS_BITS-1:0] acc;
  logic [MODULUS_BITS-1:0] j;
  logic                    bad;

  logic                    bad_next;
  logic [MODULUS_BITS:0]   diff;
  logic [MODULUS_BITS:0]   wrap;
  logic [MODULUS_BITS-1:0] acc_next;

  assign bad_next = (divisor == '0) || (divisor >= modulus) || (dividend >= modulus);

  // acc holds i*j mod p; stepping j down by one subtracts i and wraps by p.
  assign diff     = {1'b0, acc} - {1'b0, i_op};
  assign wrap     = diff + {1'b0, p_op};
  assign acc_next = diff[MODULUS_BITS] ? wrap[MODULUS_BITS-1:0] : diff[MODULUS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_op <= dividend;
      i_op <= divisor;
      p_op <= modulus;
      acc  <= modulus - divisor;
      j    <= modulus - MODULUS_BITS'(1);
      bad  <= bad_next;
    end else if (cmd.step) begin
      acc <= acc_next;
      j   <= j - MODULUS_BITS'(1);
    end
    if (cmd.capture) begin
      quotient <= (!bad && (acc == c_op)) ? j : '0;
      error    <= bad;
    end
  end

  assign status.bad   = bad;
  assign status.found = (acc == c_op);
  assign status.last  = (j == MODULUS_BITS'(1));

  a_step_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (j != '0))
    else $error("search stepped past j of one");

  a_acc_in_field: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (acc < p_op))
    else $error("running product left the field");

endmodule

FILE: design/pfmd_ctrl.sv
// Controller: sequences one division at a time and owns the result valid flag.
module pfmd_ctrl
  import pfmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   done;
  logic   room;

  assign done = status.bad || status.found || status.last;
  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (done && room) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SEARCH: begin
        cmd.step    = !done;
        cmd.capture = done && room;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_capture_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || !out_stall))
    else $error("result written over an unread result");

  a_capture_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> out_valid)
    else $error("captured result not presented");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.step, cmd.capture}) <= 1)
    else $error("controller issued overlapping commands");

endmodule

FILE: design/prime_field_modular_divider.sv
// Top level of the prime-field modular divider.
//
// This block divides one element of GF(p) by another: for a dividend c and a
// nonzero divisor i, both below the modulus p, it returns the quotient j with
// (i * j) mod p equal to c, and error low. A zero divisor, or either operand at
// or above the modulus, gives quotient 0 with error high; a dividend of 0 gives
// quotient 0. The modulus is written through the configuration port at byte
// address 0 and resets to 2; it should be prime, and for a composite value the
// block still returns the largest j in 1..p-1 that matches, or 0 when none does.
// Internally the datapath keeps the running product i*j mod p and walks j down
// from p-1, one candidate per clock with a single subtract-and-wrap, stopping at
// the first match. Bad operands end the search at once, and with no match it
// runs down to j = 1; the result is then captured once the output register is
// free. One item is worked on at a time: in_stall is high from acceptance until
// the result is written to the output register. That register holds the result
// beat until it is taken, and the block accepts the next input beat while it
// waits.
module prime_field_modular_divider
  import pfmd_pkg::*;
#(
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_BITS-1:0]  paddr,
  input  logic [CFG_DATA_BITS-1:0]  pwdata,
  output logic [CFG_DATA_BITS-1:0]  prdata,
  output logic                      pready,
  // Request channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODULUS_BITS-1:0]   dividend,
  input  logic [MODULUS_BITS-1:0]   divisor,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [MODULUS_BITS-1:0]   quotient,
  output logic                      error
);

  logic [MODULUS_BITS-1:0] modulus;
  cmd_t                    cmd;
  status_t                 status;

  // The modulus register; the user must change it only while no request is in flight; the block does not check.
  pfmd_regs #(
    .MODULUS_BITS (MODULUS_BITS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .modulus (modulus)
  );

  // The controller loads a request, steps the search until it finds a match,
  // runs out of candidates or sees bad operands, then captures the result
  // once the output register is free.
  pfmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the running product and the candidate
  // quotient, and drives the result payload straight from its output register.
  pfmd_datapath #(
    .MODULUS_BITS (MODULUS_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .modulus  (modulus),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .error    (error)
  );

endmodule
